/* hw/rtl/rmwq_pkg.sv */
// ----------------------------------------------------------------------------
// Recursive mutex with wait queue: shared definitions
// Command and status codes, and default sizes for the lock core.
// ----------------------------------------------------------------------------
package rmwq_pkg;

  localparam int unsigned WaiterDepthDef = 16;
  localparam int unsigned IdWidthDef     = 8;
  localparam int unsigned CountWidthDef  = 8;

  localparam int unsigned CmdWidth    = 2;
  localparam int unsigned StatusWidth = 4;

  typedef enum logic [CmdWidth-1:0] {
    CmdTryLock = 2'd0,
    CmdLock    = 2'd1,
    CmdUnlock  = 2'd2
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    StGranted  = 4'd0,
    StRecursed = 4'd1,
    StBusy     = 4'd2,
    StBlocked  = 4'd3,
    StReleased = 4'd4,
    StFreed    = 4'd5,
    StHanded   = 4'd6,
    StIgnored  = 4'd7,
    StFull     = 4'd8
  } status_e;

endpackage

/* hw/rtl/rmwq_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (read-first).
// ----------------------------------------------------------------------------
module rmwq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rmwq_ctrl.sv */
// ----------------------------------------------------------------------------
// Lock state and waiter queue
// Decides one request per step, holds owner, count and the waiter FIFO.
// ----------------------------------------------------------------------------
module rmwq_ctrl #(
  parameter int unsigned WaiterDepth = rmwq_pkg::WaiterDepthDef,
  parameter int unsigned IdWidth     = rmwq_pkg::IdWidthDef,
  parameter int unsigned CountWidth  = rmwq_pkg::CountWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [rmwq_pkg::CmdWidth-1:0]    cmd_i,
  input  logic                             requester_valid_i,
  input  logic [IdWidth-1:0]               requester_id_i,
  output logic [rmwq_pkg::StatusWidth-1:0] status_o,
  output logic                             woken_valid_o,
  output logic [IdWidth-1:0]               woken_id_o,
  output logic [IdWidth-1:0]               owner_id_o,
  output logic                             is_locked_o,
  output logic [CountWidth-1:0]            hold_count_o
);

  localparam int unsigned PtrW  = $clog2(WaiterDepth);
  localparam int unsigned UsedW = $clog2(WaiterDepth + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(WaiterDepth - 1);
  localparam logic [UsedW-1:0] UsedFull = UsedW'(WaiterDepth);

  logic                  held_q, held_d;
  logic [IdWidth-1:0]    holder_q, holder_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [PtrW-1:0]       head_q, tail_q, head_nx;
  logic [UsedW-1:0]      used_q;
  logic                  push, pop, push_w, pop_w;
  logic                  is_owner;
  logic [CountWidth-1:0] count_dec;
  rmwq_pkg::status_e     status;
  logic                  byp_hit_q;
  logic [IdWidth-1:0]    byp_q, ram_rdata, head_data;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    next_slot = (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  assign is_owner  = held_q && (holder_q == requester_id_i);
  assign count_dec = count_q - CountWidth'(1);
  assign head_data = byp_hit_q ? byp_q : ram_rdata;

  always_comb begin
    held_d   = held_q;
    holder_d = holder_q;
    count_d  = count_q;
    push     = 1'b0;
    pop      = 1'b0;
    status   = rmwq_pkg::StIgnored;
    case (cmd_i)
      rmwq_pkg::CmdTryLock, rmwq_pkg::CmdLock: begin
        if (requester_valid_i) begin
          if (!held_q) begin
            held_d   = 1'b1;
            holder_d = requester_id_i;
            count_d  = CountWidth'(1);
            status   = rmwq_pkg::StGranted;
          end else if (is_owner) begin
            if (&count_q) begin
              status = rmwq_pkg::StFull;
            end else begin
              count_d = count_q + CountWidth'(1);
              status  = rmwq_pkg::StRecursed;
            end
          end else if (cmd_i == rmwq_pkg::CmdTryLock) begin
            status = rmwq_pkg::StBusy;
          end else if (used_q == UsedFull) begin
            status = rmwq_pkg::StFull;
          end else begin
            push   = 1'b1;
            status = rmwq_pkg::StBlocked;
          end
        end
      end
      rmwq_pkg::CmdUnlock: begin
        if (requester_valid_i && is_owner) begin
          if (count_dec != '0) begin
            count_d = count_dec;
            status  = rmwq_pkg::StReleased;
          end else if (used_q != '0) begin
            // hand over to the oldest waiter
            pop      = 1'b1;
            holder_d = head_data;
            count_d  = CountWidth'(1);
            status   = rmwq_pkg::StHanded;
          end else begin
            held_d   = 1'b0;
            holder_d = '0;
            count_d  = '0;
            status   = rmwq_pkg::StFreed;
          end
        end
      end
      default: begin
        status = rmwq_pkg::StIgnored;
      end
    endcase
  end

  assign push_w  = step_i && push;
  assign pop_w   = step_i && pop;
  assign head_nx = pop_w ? next_slot(head_q) : head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= 1'b0;
      holder_q  <= '0;
      count_q   <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      used_q    <= '0;
      byp_hit_q <= 1'b0;
    end else begin
      if (step_i) begin
        held_q   <= held_d;
        holder_q <= holder_d;
        count_q  <= count_d;
      end
      head_q <= head_nx;
      if (push_w) begin
        tail_q <= next_slot(tail_q);
      end
      if (push_w && !pop_w) begin
        used_q <= used_q + UsedW'(1);
      end else if (pop_w && !push_w) begin
        used_q <= used_q - UsedW'(1);
      end
      // a write to the slot being read shows up through the bypass
      byp_hit_q <= push_w && (tail_q == head_nx);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_q <= requester_id_i;
  end

  rmwq_ram #(
    .Width(IdWidth),
    .Depth(WaiterDepth)
  ) u_waiters (
    .clk_i  (clk_i),
    .we_i   (push_w),
    .waddr_i(tail_q),
    .wdata_i(requester_id_i),
    .raddr_i(head_nx),
    .rdata_o(ram_rdata)
  );

  assign status_o      = status;
  assign woken_valid_o = pop;
  assign woken_id_o    = pop ? head_data : '0;
  assign owner_id_o    = holder_d;
  assign is_locked_o   = held_d;
  assign hold_count_o  = count_d;

endmodule

/* hw/rtl/recursive_mutex_with_wait_queue_core.sv */
// ----------------------------------------------------------------------------
// Recursive mutex with wait queue
// Hardware recursive lock with a FIFO of blocked requesters.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | fields
//  in      | input     | in_valid_i, in_stall_o | cmd, requester_valid, requester_id
//  out     | output    | out_valid_o, out_stall_i | status, woken_valid, woken_id,
//          |           |                        | owner_id, is_locked, hold_count
//
// One request per cycle while the result channel does not stall: input register,
// decision logic, result register. The head waiter is kept ready from the queue
// RAM every cycle, so a handover does not wait on a RAM read. Reset clears the
// lock and empties the queue at once. A stalled result holds; one more request
// waits in the input register, then in_stall_o rises.
// ----------------------------------------------------------------------------
module recursive_mutex_with_wait_queue_core #(
  parameter int unsigned WaiterDepth = rmwq_pkg::WaiterDepthDef,
  parameter int unsigned IdWidth     = rmwq_pkg::IdWidthDef,
  parameter int unsigned CountWidth  = rmwq_pkg::CountWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rmwq_pkg::CmdWidth-1:0]    cmd_i,
  input  logic                             requester_valid_i,
  input  logic [IdWidth-1:0]               requester_id_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rmwq_pkg::StatusWidth-1:0] status_o,
  output logic                             woken_valid_o,
  output logic [IdWidth-1:0]               woken_id_o,
  output logic [IdWidth-1:0]               owner_id_o,
  output logic                             is_locked_o,
  output logic [CountWidth-1:0]            hold_count_o
);

  logic                             in_vq;
  logic [rmwq_pkg::CmdWidth-1:0]    cmd_q;
  logic                             rv_q;
  logic [IdWidth-1:0]               id_q;
  logic                             out_vq;
  logic                             accept, adv;

  logic [rmwq_pkg::StatusWidth-1:0] status_d, status_q;
  logic                             woken_valid_d, woken_valid_q;
  logic [IdWidth-1:0]               woken_id_d, woken_id_q;
  logic [IdWidth-1:0]               owner_d, owner_q;
  logic                             locked_d, locked_q;
  logic [CountWidth-1:0]            count_d, count_q;

  assign adv        = in_vq && (!out_vq || !out_stall_i);
  assign in_stall_o = in_vq && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq  <= 1'b0;
      out_vq <= 1'b0;
    end else begin
      if (accept) begin
        in_vq <= 1'b1;
      end else if (adv) begin
        in_vq <= 1'b0;
      end
      if (adv) begin
        out_vq <= 1'b1;
      end else if (!out_stall_i) begin
        out_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      rv_q  <= requester_valid_i;
      id_q  <= requester_id_i;
    end
    if (adv) begin
      status_q      <= status_d;
      woken_valid_q <= woken_valid_d;
      woken_id_q    <= woken_id_d;
      owner_q       <= owner_d;
      locked_q      <= locked_d;
      count_q       <= count_d;
    end
  end

  rmwq_ctrl #(
    .WaiterDepth(WaiterDepth),
    .IdWidth    (IdWidth),
    .CountWidth (CountWidth)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (adv),
    .cmd_i            (cmd_q),
    .requester_valid_i(rv_q),
    .requester_id_i   (id_q),
    .status_o         (status_d),
    .woken_valid_o    (woken_valid_d),
    .woken_id_o       (woken_id_d),
    .owner_id_o       (owner_d),
    .is_locked_o      (locked_d),
    .hold_count_o     (count_d)
  );

  assign out_valid_o   = out_vq;
  assign status_o      = status_q;
  assign woken_valid_o = woken_valid_q;
  assign woken_id_o    = woken_id_q;
  assign owner_id_o    = owner_q;
  assign is_locked_o   = locked_q;
  assign hold_count_o  = count_q;

endmodule

/* tb/lock_result_checker.sv */
// ----------------------------------------------------------------------------
// Recursive mutex with wait queue: result checker
// Watches the request and result channels of the lock core, keeps its own
// copy of the lock state and waiter queue, predicts one result per accepted
// request and compares every accepted result field by field, in order.
// ----------------------------------------------------------------------------
module lock_result_checker
  import rmwq_pkg::*;
#(
  parameter int unsigned WaiterDepth = WaiterDepthDef,
  parameter int unsigned IdWidth     = IdWidthDef,
  parameter int unsigned CountWidth  = CountWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [CmdWidth-1:0]    cmd_i,
  input  logic                   requester_valid_i,
  input  logic [IdWidth-1:0]     requester_id_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [StatusWidth-1:0] status_i,
  input  logic                   woken_valid_i,
  input  logic [IdWidth-1:0]     woken_id_i,
  input  logic [IdWidth-1:0]     owner_id_i,
  input  logic                   is_locked_i,
  input  logic [CountWidth-1:0]  hold_count_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o,
  output int unsigned            checked_o,
  output int unsigned            handed_o,
  output int unsigned            refused_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e               status;
    logic                  woken_valid;
    logic [IdWidth-1:0]    woken_id;
    logic [IdWidth-1:0]    owner_id;
    logic                  is_locked;
    logic [CountWidth-1:0] hold_count;
  } lock_result_t;

  localparam logic [CountWidth-1:0] DepthMax = '1;

  logic                  lock_held;
  logic [IdWidth-1:0]    lock_owner;
  logic [CountWidth-1:0] lock_depth;
  logic [IdWidth-1:0]    waiter_ids[$];
  lock_result_t          awaited_results[$];
  int unsigned           errors;
  int unsigned           checked;
  int unsigned           handed;
  int unsigned           refused;

  // Work out the result of one request and advance the lock state.
  task automatic apply_request(input logic [CmdWidth-1:0] cmd, input logic present,
                               input logic [IdWidth-1:0] id, output lock_result_t res);
    res        = '0;
    res.status = StIgnored;
    if (present) begin
      case (cmd)
        CmdTryLock, CmdLock: begin
          if (!lock_held) begin
            lock_held  = 1'b1;
            lock_owner = id;
            lock_depth = CountWidth'(1);
            res.status = StGranted;
          end else if (lock_owner == id) begin
            if (lock_depth == DepthMax) begin
              res.status = StFull;
            end else begin
              lock_depth = lock_depth + 1'b1;
              res.status = StRecursed;
            end
          end else if (cmd == CmdTryLock) begin
            res.status = StBusy;
          end else if (waiter_ids.size() >= WaiterDepth) begin
            res.status = StFull;
          end else begin
            waiter_ids.push_back(id);
            res.status = StBlocked;
          end
        end
        CmdUnlock: begin
          if (lock_held && lock_owner == id) begin
            lock_depth = lock_depth - 1'b1;
            if (lock_depth != 0) begin
              res.status = StReleased;
            end else if (waiter_ids.size() != 0) begin
              lock_owner      = waiter_ids.pop_front();
              lock_depth      = CountWidth'(1);
              res.woken_valid = 1'b1;
              res.woken_id    = lock_owner;
              res.status      = StHanded;
            end else begin
              lock_held  = 1'b0;
              lock_owner = '0;
              res.status = StFreed;
            end
          end
        end
        default: ;
      endcase
    end
    res.owner_id   = lock_held ? lock_owner : '0;
    res.is_locked  = lock_held;
    res.hold_count = lock_held ? lock_depth : '0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lock_result_t res;
    lock_result_t want;
    if (!rst_ni) begin
      lock_held  = 1'b0;
      lock_owner = '0;
      lock_depth = '0;
      waiter_ids.delete();
      awaited_results.delete();
      errors  = 0;
      checked = 0;
      handed  = 0;
      refused = 0;
    end else begin
      // Compare first: a result accepted here belongs to an earlier item.
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with status %0d arrived with nothing awaited", status_i);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, status_i);
          check_field("woken_valid", want.woken_valid, woken_valid_i);
          check_field("woken_id", want.woken_id, woken_id_i);
          check_field("owner_id", want.owner_id, owner_id_i);
          check_field("is_locked", want.is_locked, is_locked_i);
          check_field("hold_count", want.hold_count, hold_count_i);
          checked++;
          if (want.status == StHanded) handed++;
          if (want.status == StFull) refused++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_request(cmd_i, requester_valid_i, requester_id_i, res);
        awaited_results.push_back(res);
      end
    end
    fail_count_o <= errors;
    pending_o    <= awaited_results.size();
    checked_o    <= checked;
    handed_o     <= handed;
    refused_o    <= refused;
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Recursive mutex with wait queue: testbench top
// Drives lock requests into the core with random gaps and result stalls,
// including a long result hold-off and a full drain, and reports the verdict
// from the result checker beside the core.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import rmwq_pkg::*;

  localparam logic [CmdWidth-1:0] CmdReserved = 2'd3;
  localparam int unsigned         HoldOffLen  = 60;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [CmdWidth-1:0]    cmd = CmdTryLock;
  logic                   req_valid = 1'b0;
  logic [IdWidthDef-1:0]  req_id = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [StatusWidth-1:0] status;
  logic                   woken_valid;
  logic [IdWidthDef-1:0]  woken_id;
  logic [IdWidthDef-1:0]  owner_id;
  logic                   is_locked;
  logic [CountWidthDef-1:0] hold_count;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned handed;
  int unsigned refused;

  int unsigned           idle_pct = 0;
  int unsigned           stall_pct = 0;
  int unsigned           hold_off_asked = 0;
  int unsigned           hold_off_taken = 0;
  int unsigned           hold_off_left = 0;
  int unsigned           requests_sent = 0;
  logic [IdWidthDef-1:0] seen_owner = '0;
  logic [IdWidthDef-1:0] pool[4];
  logic [IdWidthDef-1:0] wait_ids[16];

  recursive_mutex_with_wait_queue_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .cmd_i             (cmd),
    .requester_valid_i (req_valid),
    .requester_id_i    (req_id),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_o          (status),
    .woken_valid_o     (woken_valid),
    .woken_id_o        (woken_id),
    .owner_id_o        (owner_id),
    .is_locked_o       (is_locked),
    .hold_count_o      (hold_count)
  );

  lock_result_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .cmd_i             (cmd),
    .requester_valid_i (req_valid),
    .requester_id_i    (req_id),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .status_i          (status),
    .woken_valid_i     (woken_valid),
    .woken_id_i        (woken_id),
    .owner_id_i        (owner_id),
    .is_locked_i       (is_locked),
    .hold_count_i      (hold_count),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .checked_o         (checked),
    .handed_o          (handed),
    .refused_o         (refused)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("testbench: errors");
    $finish;
  end

  // Result side: random stalls, or a counted hold-off when one is asked for.
  always @(posedge clk_i) begin
    if (hold_off_left != 0) begin
      out_stall     <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_taken != hold_off_asked) begin
      out_stall      <= 1'b1;
      hold_off_taken <= hold_off_asked;
      hold_off_left  <= HoldOffLen;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Track the owner the core reports, to aim unlocks at it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) seen_owner <= owner_id;
  end

  task automatic issue_request(input logic [CmdWidth-1:0] c, input logic present,
                               input logic [IdWidthDef-1:0] id);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    req_valid <= present;
    req_id    <= id;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_request();
    int unsigned           pick;
    int unsigned           aim;
    logic [CmdWidth-1:0]   c;
    logic                  present;
    logic [IdWidthDef-1:0] id;
    pick    = $urandom_range(99);
    aim     = $urandom_range(99);
    present = 1'b1;
    if (pick < 5) begin
      // noise: reserved command or no requester
      c       = CmdWidth'($urandom_range(3));
      present = (c == CmdReserved) ? 1'($urandom_range(1)) : 1'b0;
      id      = IdWidthDef'($urandom_range(255));
    end else begin
      if (pick < 40)      c = CmdLock;
      else if (pick < 60) c = CmdTryLock;
      else                c = CmdUnlock;
      if (c == CmdUnlock) begin
        id = (aim < 75) ? seen_owner : pool[$urandom_range(3)];
      end else if (aim < 20) begin
        id = seen_owner;
      end else if (aim < 80) begin
        id = pool[$urandom_range(3)];
      end else begin
        id = IdWidthDef'($urandom_range(255));
      end
    end
    issue_request(c, present, id);
  endtask

  task automatic random_phase(input int unsigned idle, input int unsigned stall,
                              input int unsigned count);
    idle_pct  = idle;
    stall_pct = stall;
    foreach (pool[k]) pool[k] = IdWidthDef'($urandom_range(255));
    for (int n = 0; n < count; n++) begin
      if (n == count / 2 && idle == 0 && stall != 0) hold_off_asked <= hold_off_asked + 1;
      if (n == count / 2 && idle != 0 && stall != 0) wait_drained();
      random_request();
    end
  endtask

  initial begin
    logic [IdWidthDef-1:0] burst_id;
    logic [IdWidthDef-1:0] other_id;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored cases, grant and recursion, busy, a full queue,
    // release and handover, then serve every waiter until the lock is free.
    issue_request(CmdUnlock, 1'b1, 8'd5);
    issue_request(CmdTryLock, 1'b0, 8'd0);
    issue_request(CmdReserved, 1'b1, 8'd255);
    issue_request(CmdTryLock, 1'b1, 8'd0);
    issue_request(CmdTryLock, 1'b1, 8'd0);
    issue_request(CmdLock, 1'b1, 8'd0);
    issue_request(CmdTryLock, 1'b1, 8'd255);
    issue_request(CmdUnlock, 1'b1, 8'd255);
    wait_ids[0] = 8'd255;
    wait_ids[1] = 8'd255;
    for (int k = 2; k < 16; k++) wait_ids[k] = IdWidthDef'(k - 1);
    foreach (wait_ids[k]) issue_request(CmdLock, 1'b1, wait_ids[k]);
    issue_request(CmdLock, 1'b1, 8'hAA);
    repeat (3) issue_request(CmdUnlock, 1'b1, 8'd0);
    foreach (wait_ids[k]) issue_request(CmdUnlock, 1'b1, wait_ids[k]);

    // Deep recursion up to the count limit, then unwind with other
    // requesters interleaved; hold the results off part way through.
    burst_id = IdWidthDef'($urandom_range(255));
    for (int k = 0; k < 258; k++) begin
      if (k == 100) hold_off_asked <= hold_off_asked + 1;
      issue_request($urandom_range(1) ? CmdLock : CmdTryLock, 1'b1, burst_id);
    end
    for (int k = 0; k < 255; k++) begin
      if ($urandom_range(3) == 0) begin
        other_id = burst_id ^ 8'($urandom_range(1, 255));
        issue_request(CmdWidth'($urandom_range(2)), 1'b1, other_id);
      end
      issue_request(CmdUnlock, 1'b1, burst_id);
    end

    random_phase(0, 0, 200);
    random_phase(64, 0, 200);
    random_phase(0, 64, 200);
    random_phase(38, 38, 200);

    wait_drained();
    repeat (16) @(posedge clk_i);
    $display("summary: %0d requests sent, %0d results checked", requests_sent, checked);
    $display("summary: %0d handovers and %0d full or saturated refusals seen",
             handed, refused);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
